@@ src/zone_occupancy_key_detector_core_defines.svh @@
// Assertion macros shared by the zone occupancy key detector RTL.
`ifndef ZONE_OCCUPANCY_KEY_DETECTOR_CORE_DEFINES_SVH
`define ZONE_OCCUPANCY_KEY_DETECTOR_CORE_DEFINES_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define ZOKD_ASSERT_SAME(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define ZOKD_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/zokd_pkg.sv @@
// Shared constants and the zone bound table of the zone occupancy key detector.
`default_nettype none
package zokd_pkg;

	localparam int ZONES_DEFAULT      = 14;
	localparam int COORD_BITS_DEFAULT = 10;
	localparam int BOUND_COUNT        = 15;
	localparam int BOUND_W            = 10;

	localparam int PIX_W         = 8;
	localparam int BAND_TOP_W    = 10;
	localparam int BAND_HEIGHT_W = 6;
	localparam int THRESH_W      = 8;
	localparam int FILL_W        = 4;
	localparam int FH_W          = FILL_W + BAND_HEIGHT_W;

	localparam int COUNT_W = 12;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam int MASK_W  = 14;
	localparam int NEED_W  = 17;
	localparam int WIDTH_W = 7;
	localparam int OUT_W   = ((2 * MASK_W + 7) / 8) * 8;

	localparam int GRAY_SUM_W  = 22;
	localparam int GRAY_SHIFT  = 14;
	localparam int GRAY_B      = 1868;
	localparam int GRAY_G      = 9617;
	localparam int GRAY_R      = 4899;
	localparam int GRAY_ROUND  = 8192;

	localparam int APB_DATA_W = 32;
	localparam int ADDR_W     = 4;
	localparam int REG_IDX_W  = 2;

	localparam logic [REG_IDX_W-1:0] REG_BAND_TOP    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_BAND_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_THRESHOLD   = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_FILL        = 2'd3;

	localparam logic [BAND_TOP_W-1:0]    RST_BAND_TOP    = 10'd333;
	localparam logic [BAND_HEIGHT_W-1:0] RST_BAND_HEIGHT = 6'd58;
	localparam logic [THRESH_W-1:0]      RST_THRESHOLD   = 8'd100;
	localparam logic [FILL_W-1:0]        RST_FILL        = 4'd7;

	// Left column edge of each zone; zone i spans [bound i, bound i+1).
	function automatic logic [BOUND_W-1:0] zone_bound(input int idx);
		logic [BOUND_W-1:0] b;
		case (idx)
			0:  b = 10'd66;
			1:  b = 10'd107;
			2:  b = 10'd145;
			3:  b = 10'd182;
			4:  b = 10'd215;
			5:  b = 10'd249;
			6:  b = 10'd284;
			7:  b = 10'd317;
			8:  b = 10'd349;
			9:  b = 10'd386;
			10: b = 10'd421;
			11: b = 10'd456;
			12: b = 10'd492;
			13: b = 10'd529;
			14: b = 10'd568;
			default: b = '0;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

@@ src/zone_occupancy_key_detector_core.sv @@
// Top level of the zone occupancy key detector: pixel pipeline, zone counters and judging.
`default_nettype none
`include "zone_occupancy_key_detector_core_defines.svh"

// The block watches a horizontal band of a BGR pixel stream, splits it into
// column zones and reports once per frame which zones are occupied by bright
// pixels. Each input beat carries one pixel with its column and row; tlast
// marks the last pixel of a frame. A pixel counts for its zone when its row
// lies in the band set by band_top and band_height and its BT.601 gray level
// is above pixel_threshold. On the tlast pixel, after that pixel is counted,
// every zone is judged: it is pressed when ten times its count exceeds
// fill_tenths times zone width times band height. One output beat then
// carries the pressed mask and the onset mask (zones pressed now but not in
// the previous frame), with bit n belonging to note n = ZONES-1-zone, and all
// counters clear. Pixels without tlast give no output beat. Counters
// saturate at 4095. The block takes one pixel per clock. A pixel passes an
// input register, a gray and zone decode stage, a counter update stage and a
// judging stage, and a frame's result is then loaded into the output register.
// The input side stalls only while a judged frame result waits behind an
// output beat that has not been taken. Configuration is to be written through
// the APB port only while no frame is in flight; the block does not enforce
// it. Registers sit at byte addresses 0, 4, 8 and 12.
module zone_occupancy_key_detector_core #(
	parameter int ZONES      = zokd_pkg::ZONES_DEFAULT,
	parameter int COORD_BITS = zokd_pkg::COORD_BITS_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// blue[7:0], green, red, column, row (COORD_BITS each), zero fill
	input  wire logic [((3*zokd_pkg::PIX_W+2*COORD_BITS+7)/8)*8-1:0] s_tdata,
	input  wire logic                              s_tlast,      // end_of_frame
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// pressed_mask[13:0], onset_mask[27:14], zero fill
	output logic [zokd_pkg::OUT_W-1:0]             m_tdata,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [zokd_pkg::ADDR_W-1:0]       paddr,
	input  wire logic [zokd_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [zokd_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                   pready
);

	localparam int PIX_W = zokd_pkg::PIX_W;
	localparam int CMP_W = (COORD_BITS > 10) ? COORD_BITS + 1 : 11;
	localparam int COUNT_W = zokd_pkg::COUNT_W;
	localparam int NEED_W = zokd_pkg::NEED_W;
	localparam int GSW = zokd_pkg::GRAY_SUM_W;
	localparam int MASK_W = zokd_pkg::MASK_W;

	// Configuration registers.
	logic [zokd_pkg::BAND_TOP_W-1:0]    band_top_q;
	logic [zokd_pkg::BAND_HEIGHT_W-1:0] band_height_q;
	logic [zokd_pkg::THRESH_W-1:0]      pixel_threshold_q;
	logic [zokd_pkg::FILL_W-1:0]        fill_tenths_q;
	logic [zokd_pkg::FH_W-1:0]          fh_q;
	logic                               cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_top_q        <= zokd_pkg::RST_BAND_TOP;
			band_height_q     <= zokd_pkg::RST_BAND_HEIGHT;
			pixel_threshold_q <= zokd_pkg::RST_THRESHOLD;
			fill_tenths_q     <= zokd_pkg::RST_FILL;
		end else if (cfg_write) begin
			case (paddr[zokd_pkg::ADDR_W-1 -: zokd_pkg::REG_IDX_W])
				zokd_pkg::REG_BAND_TOP:    band_top_q <= pwdata[zokd_pkg::BAND_TOP_W-1:0];
				zokd_pkg::REG_BAND_HEIGHT: band_height_q <= pwdata[zokd_pkg::BAND_HEIGHT_W-1:0];
				zokd_pkg::REG_THRESHOLD:   pixel_threshold_q <= pwdata[zokd_pkg::THRESH_W-1:0];
				zokd_pkg::REG_FILL:        fill_tenths_q <= pwdata[zokd_pkg::FILL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[zokd_pkg::ADDR_W-1 -: zokd_pkg::REG_IDX_W])
			zokd_pkg::REG_BAND_TOP:    prdata = zokd_pkg::APB_DATA_W'(band_top_q);
			zokd_pkg::REG_BAND_HEIGHT: prdata = zokd_pkg::APB_DATA_W'(band_height_q);
			zokd_pkg::REG_THRESHOLD:   prdata = zokd_pkg::APB_DATA_W'(pixel_threshold_q);
			zokd_pkg::REG_FILL:        prdata = zokd_pkg::APB_DATA_W'(fill_tenths_q);
			default:                   prdata = '0;
		endcase
	end

	// The product of fill and band height follows the registers in the next cycle,
	// well before any frame that uses it reaches the judging stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fh_q <= zokd_pkg::FH_W'(zokd_pkg::RST_FILL * zokd_pkg::RST_BAND_HEIGHT);
		end else begin
			fh_q <= {{zokd_pkg::BAND_HEIGHT_W{1'b0}}, fill_tenths_q} *
				{{zokd_pkg::FILL_W{1'b0}}, band_height_q};
		end
	end

	// Pipeline flow control. Only a judged result stuck in stage 3 holds things up.
	logic valid_s1, valid_s2, valid_s3;
	logic m_valid_q;
	logic advance;

	assign advance  = !(valid_s3 && m_valid_q && !m_tready);
	assign s_tready = advance;
	assign m_tvalid = m_valid_q;

	// Stage 1: input register.
	logic [PIX_W-1:0]      blue_s1, green_s1, red_s1;
	logic [COORD_BITS-1:0] column_s1, row_s1;
	logic                  eof_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s_tvalid) begin
			blue_s1   <= s_tdata[0 +: PIX_W];
			green_s1  <= s_tdata[PIX_W +: PIX_W];
			red_s1    <= s_tdata[2*PIX_W +: PIX_W];
			column_s1 <= s_tdata[3*PIX_W +: COORD_BITS];
			row_s1    <= s_tdata[3*PIX_W+COORD_BITS +: COORD_BITS];
			eof_s1    <= s_tlast;
		end
	end

	// Gray level, band test and zone decode.
	logic [GSW-1:0]   gray_sum;
	logic [PIX_W-1:0] gray;
	logic [CMP_W-1:0] row_ext, col_ext, band_lo, band_hi;
	logic             counts_pixel;
	logic [ZONES-1:0] zone_hit;

	assign gray_sum = GSW'(zokd_pkg::GRAY_B) * GSW'(blue_s1) +
		GSW'(zokd_pkg::GRAY_G) * GSW'(green_s1) +
		GSW'(zokd_pkg::GRAY_R) * GSW'(red_s1) +
		GSW'(zokd_pkg::GRAY_ROUND);
	assign gray    = gray_sum[zokd_pkg::GRAY_SHIFT +: PIX_W];
	assign row_ext = CMP_W'(row_s1);
	assign col_ext = CMP_W'(column_s1);
	assign band_lo = CMP_W'(band_top_q);
	assign band_hi = CMP_W'(band_top_q) + CMP_W'(band_height_q);
	assign counts_pixel = (row_ext >= band_lo) && (row_ext < band_hi) &&
		(gray > pixel_threshold_q);

	for (genvar z = 0; z < ZONES; z++) begin : g_hit
		if (z < zokd_pkg::BOUND_COUNT - 1) begin : g_bounded
			assign zone_hit[z] = counts_pixel &&
				(col_ext >= CMP_W'(zokd_pkg::zone_bound(z))) &&
				(col_ext < CMP_W'(zokd_pkg::zone_bound(z + 1)));
		end else begin : g_unbounded
			assign zone_hit[z] = 1'b0;
		end
	end

	// Stage 2: zone hit vector; the counters update here.
	logic [ZONES-1:0] hit_s2;
	logic             eof_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			hit_s2 <= zone_hit;
			eof_s2 <= eof_s1;
		end
	end

	logic [COUNT_W-1:0] count_q  [ZONES];
	logic [COUNT_W-1:0] cnt_next [ZONES];
	logic [COUNT_W-1:0] cnt_s3   [ZONES];

	always_comb begin
		for (int z = 0; z < ZONES; z++) begin
			if (hit_s2[z] && (count_q[z] != zokd_pkg::COUNT_MAX)) begin
				cnt_next[z] = count_q[z] + COUNT_W'(1);
			end else begin
				cnt_next[z] = count_q[z];
			end
		end
	end

	// Counters clear once the last pixel of a frame has been counted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int z = 0; z < ZONES; z++) begin
				count_q[z] <= '0;
			end
		end else if (advance && valid_s2) begin
			for (int z = 0; z < ZONES; z++) begin
				count_q[z] <= eof_s2 ? '0 : cnt_next[z];
			end
		end
	end

	// Stage 3: final counts of a frame, judged against the fill threshold.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2 && eof_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2 && eof_s2) begin
			for (int z = 0; z < ZONES; z++) begin
				cnt_s3[z] <= cnt_next[z];
			end
		end
	end

	logic [ZONES-1:0]  zone_press;
	logic [MASK_W-1:0] pressed;

	for (genvar z = 0; z < ZONES; z++) begin : g_judge
		if (z < zokd_pkg::BOUND_COUNT - 1) begin : g_bounded
			localparam logic [zokd_pkg::WIDTH_W-1:0] ZONE_WIDTH =
				zokd_pkg::WIDTH_W'(zokd_pkg::zone_bound(z + 1) - zokd_pkg::zone_bound(z));
			logic [NEED_W-1:0] need;
			logic [NEED_W-1:0] tenx;
			assign need = NEED_W'(fh_q) * NEED_W'(ZONE_WIDTH);
			assign tenx = (NEED_W'(cnt_s3[z]) << 3) + (NEED_W'(cnt_s3[z]) << 1);
			assign zone_press[z] = tenx > need;
		end else begin : g_unbounded
			assign zone_press[z] = 1'b0;
		end
	end

	// Note n belongs to zone ZONES-1-n.
	for (genvar n = 0; n < MASK_W; n++) begin : g_note
		if (n < ZONES) begin : g_used
			assign pressed[n] = zone_press[ZONES-1-n];
		end else begin : g_unused
			assign pressed[n] = 1'b0;
		end
	end

	// Output register and the previous frame's pressed mask.
	logic [MASK_W-1:0] pressed_q, onset_q, prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			prev_q    <= '0;
		end else begin
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (valid_s3 && advance) begin
				m_valid_q <= 1'b1;
				prev_q    <= pressed;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && advance) begin
			pressed_q <= pressed;
			onset_q   <= pressed & ~prev_q;
		end
	end

	assign m_tdata = zokd_pkg::OUT_W'({onset_q, pressed_q});

	// An onset is always also a press.
	`ZOKD_ASSERT_SAME(a_onset_in_pressed, clk, arst_n, m_valid_q, (onset_q & ~pressed_q) == '0, "onset bit without press")
	// The input side only stalls behind a waiting result.
	`ZOKD_ASSERT_SAME(a_stall_cause, clk, arst_n, !s_tready, m_valid_q && valid_s3, "input stalled without a waiting result")
	// The first zone's counter starts from zero after the last pixel of a frame.
	`ZOKD_ASSERT_NEXT(a_count_clear, clk, arst_n, advance && valid_s2 && eof_s2, count_q[0] == '0, "zone counter not cleared at frame end")
	// A judged frame lands in the output register and becomes the previous mask.
	`ZOKD_ASSERT_NEXT(a_result_load, clk, arst_n, valid_s3 && advance, m_valid_q && (prev_q == pressed_q), "frame result not loaded")

endmodule
`default_nettype wire

@@ bench/zokd_checker.sv @@
// Scoreboard for the zone occupancy key detector: predicts the key masks and checks each result beat.
module zokd_checker #(
	parameter int IN_W = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [IN_W-1:0]                   s_tdata,
	input  logic                              s_tlast,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [zokd_pkg::OUT_W-1:0]        m_tdata,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic                              pready,
	input  logic [zokd_pkg::ADDR_W-1:0]       paddr,
	input  logic [zokd_pkg::APB_DATA_W-1:0]   pwdata,
	output int                                failures,
	output int                                awaited,
	output int                                frames_checked
);

	localparam int KEYS = 14;

	typedef struct packed {
		logic [KEYS-1:0] onset;
		logic [KEYS-1:0] pressed;
	} key_masks_t;

	// Left column edge of each zone and the right edge of the last one.
	int unsigned zone_edge [KEYS+1] = '{66, 107, 145, 182, 215, 249, 284, 317,
		349, 386, 421, 456, 492, 529, 568};

	logic [9:0]      band_top;
	logic [5:0]      band_height;
	logic [7:0]      lit_level;
	logic [3:0]      fill_tenths;
	logic [11:0]     zone_hits [KEYS];
	logic [KEYS-1:0] held_keys;
	key_masks_t      key_queue [$];

	// Counts one pixel and, on the last pixel of a frame, judges every zone.
	task automatic count_pixel(input logic [IN_W-1:0] px, input logic eof);
		int unsigned gray, col, row, need;
		logic [KEYS-1:0] keys;
		key_masks_t k;
		col  = int'(px[33:24]);
		row  = int'(px[43:34]);
		gray = (1868 * int'(px[7:0]) + 9617 * int'(px[15:8]) + 4899 * int'(px[23:16])
			+ 8192) >> 14;
		if (row >= int'(band_top) && row < int'(band_top) + int'(band_height) &&
			gray > int'(lit_level)) begin
			for (int z = 0; z < KEYS; z++) begin
				if (col >= zone_edge[z] && col < zone_edge[z+1] && zone_hits[z] != '1)
					zone_hits[z] = zone_hits[z] + 12'd1;
			end
		end
		if (eof) begin
			keys = '0;
			for (int z = 0; z < KEYS; z++) begin
				need = int'(fill_tenths) * (zone_edge[z+1] - zone_edge[z]) * int'(band_height);
				if (10 * int'(zone_hits[z]) > need)
					keys[KEYS-1-z] = 1'b1;
				zone_hits[z] = '0;
			end
			k.pressed = keys;
			k.onset   = keys & ~held_keys;
			held_keys = keys;
			key_queue.push_back(k);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : scoreboard
		key_masks_t got, want;
		if (!arst_n) begin
			band_top       = zokd_pkg::RST_BAND_TOP;
			band_height    = zokd_pkg::RST_BAND_HEIGHT;
			lit_level      = zokd_pkg::RST_THRESHOLD;
			fill_tenths    = zokd_pkg::RST_FILL;
			held_keys      = '0;
			for (int z = 0; z < KEYS; z++)
				zone_hits[z] = '0;
			key_queue.delete();
			failures       <= 0;
			awaited        <= 0;
			frames_checked <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					zokd_pkg::REG_BAND_TOP:    band_top    = pwdata[9:0];
					zokd_pkg::REG_BAND_HEIGHT: band_height = pwdata[5:0];
					zokd_pkg::REG_THRESHOLD:   lit_level   = pwdata[7:0];
					zokd_pkg::REG_FILL:        fill_tenths = pwdata[3:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				count_pixel(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				got = m_tdata[2*KEYS-1:0];
				frames_checked <= frames_checked + 1;
				if (key_queue.size() == 0) begin
					$error("result beat with no frame pending: pressed %h onset %h",
						got.pressed, got.onset);
					failures <= failures + 1;
				end else begin
					want = key_queue.pop_front();
					if (got != want)
						failures <= failures + 1;
					if (got.pressed != want.pressed)
						$error("pressed_mask: expected %h, actual %h", want.pressed, got.pressed);
					if (got.onset != want.onset)
						$error("onset_mask: expected %h, actual %h", want.onset, got.onset);
				end
			end
			awaited <= key_queue.size();
		end
	end

endmodule

@@ bench/tb.sv @@
// Testbench top for the zone occupancy key detector: clock, reset, stimulus and verdict.
module tb;

	localparam int IN_W  = ((3 * zokd_pkg::PIX_W + 2 * 10 + 7) / 8) * 8;
	// Cycles a pixel may still spend in the pipeline after the last result beat.
	localparam int DRAIN = 8;
	// Cycles without any beat on any port before the run is declared hung.
	localparam int HANG_LIMIT = 20000;
	localparam int RANDOM_PIXELS = 1500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Pixel stream toward the block.
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	// blue[7:0], green[15:8], red[23:16], column[33:24], row[43:34], zero fill
	logic [IN_W-1:0]                   s_tdata = '0;
	logic                              s_tlast = 1'b0;     // end_of_frame

	// Key mask stream out of the block.
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	// pressed_mask[13:0], onset_mask[27:14], zero fill
	logic [zokd_pkg::OUT_W-1:0]        m_tdata;

	logic                              psel = 1'b0;
	logic                              penable = 1'b0;
	logic                              pwrite = 1'b0;
	logic [zokd_pkg::ADDR_W-1:0]       paddr = '0;
	logic [zokd_pkg::APB_DATA_W-1:0]   pwdata = '0;
	logic [zokd_pkg::APB_DATA_W-1:0]   prdata;
	logic                              pready;

	int failures;
	int awaited;
	int frames_checked;

	// The stimulus keeps its own copy of the settings so it can aim pixels at the band.
	int cur_top = int'(zokd_pkg::RST_BAND_TOP);
	int cur_height = int'(zokd_pkg::RST_BAND_HEIGHT);
	int cur_thresh = int'(zokd_pkg::RST_THRESHOLD);
	int cur_fill = int'(zokd_pkg::RST_FILL);

	int pixels_sent = 0;
	int settings_used = 0;
	int sender_calm = 0;
	int hold_asked = 0;
	int hold_served = 0;
	int idle_cycles = 0;

	always #6 clk = ~clk;

	zone_occupancy_key_detector_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	zokd_checker #(.IN_W(IN_W)) check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.failures       (failures),
		.awaited        (awaited),
		.frames_checked (frames_checked)
	);

	// Hang detection: any accepted beat on the pixel, mask or register port
	// restarts the count. A long output stall also stops the input side, so
	// the limit sits well above the longest stall the receiver makes.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("Watchdog: no beat for %0d cycles, %0d results outstanding",
					idle_cycles, awaited);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Receiver. Most of the time it takes results freely, now and then it
	// drops tready briefly or for a long while, and at times it runs a calm
	// stretch with no stalls at all. When the stimulus asks for it, it refuses
	// results for its longest stall so that the block's output side backs up
	// all the way to its pixel input.
	initial begin : receiver
		int stall_left;
		int calm_left;
		int pick;
		stall_left = 0;
		calm_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			pick = $urandom % 100;
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (hold_asked != hold_served) begin
				hold_served = hold_asked;
				stall_left = 400;
				m_tready <= 1'b0;
			end else if (calm_left > 0) begin
				calm_left--;
				m_tready <= 1'b1;
			end else if (pick < 15) begin
				stall_left = $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else if (pick < 18) begin
				stall_left = $urandom_range(10, 40);
				m_tready <= 1'b0;
			end else if (pick < 22) begin
				calm_left = $urandom_range(20, 100);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offers one pixel and holds it until the block takes it. An optional gap
	// comes first; tvalid stays high between back-to-back pixels.
	task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
			input logic [9:0] col, input logic [9:0] row, input logic eof,
			input bit back_to_back);
		int gap;
		int pick;
		gap = 0;
		pick = $urandom % 100;
		if (back_to_back || sender_calm > 0) begin
			if (sender_calm > 0)
				sender_calm--;
		end else if (pick < 30) begin
			gap = $urandom_range(1, 3);
		end else if (pick < 37) begin
			gap = $urandom_range(8, 40);
		end else if (pick < 42) begin
			sender_calm = $urandom_range(20, 80);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, row, col, r, g, b};
		s_tlast  <= eof;
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
	endtask

	// Stops offering pixels and waits until every frame result has come back,
	// then a little longer for pixels that produce no result.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// A register write: setup cycle, then the access cycle that commits it.
	task automatic write_reg(input logic [zokd_pkg::REG_IDX_W-1:0] idx, input int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Reprograms all four registers with the block idle.
	task automatic program_band(input int top, input int height, input int thresh,
			input int fill);
		settle();
		write_reg(zokd_pkg::REG_BAND_TOP, top);
		write_reg(zokd_pkg::REG_BAND_HEIGHT, height);
		write_reg(zokd_pkg::REG_THRESHOLD, thresh);
		write_reg(zokd_pkg::REG_FILL, fill);
		cur_top = top;
		cur_height = height;
		cur_thresh = thresh;
		cur_fill = fill;
		settings_used++;
	endtask

	// A row in the current band up to row 1023, or any row when the band is empty.
	function automatic int band_row();
		int row;
		if (cur_height == 0)
			return $urandom % 1024;
		row = cur_top + ($urandom % cur_height);
		if (row > 1023)
			row = cur_top + ($urandom % (1024 - cur_top));
		return row;
	endfunction

	// One frame of len pixels ending on the end-of-frame pixel. Most pixels
	// are bright pixels inside the band aimed at a few hot zones, so zones
	// really get pressed and released; the rest probe the zone and band
	// edges or are plain noise anywhere in the frame.
	task automatic send_frame(input int len);
		int hot [3];
		int z, col, row, lo, pick, edge_at;
		logic [7:0] b, g, r;
		for (int i = 0; i < 3; i++)
			hot[i] = $urandom % 14;
		for (int i = 0; i < len; i++) begin
			pick = $urandom % 100;
			z = hot[$urandom % 3];
			col = int'(zokd_pkg::zone_bound(z)) + ($urandom %
				(int'(zokd_pkg::zone_bound(z + 1)) - int'(zokd_pkg::zone_bound(z))));
			row = band_row();
			lo = (cur_thresh < 255 && ($urandom % 4) != 0) ? cur_thresh + 1 : 0;
			b = 8'($urandom_range(lo, 255));
			g = 8'($urandom_range(lo, 255));
			r = 8'($urandom_range(lo, 255));
			if (pick >= 90) begin
				col = $urandom % 1024;
				row = $urandom % 1024;
				b = 8'($urandom);
				g = 8'($urandom);
				r = 8'($urandom);
			end else if (pick >= 80) begin
				// Just on or just before a zone edge, and sometimes one row off the band.
				col = int'(zokd_pkg::zone_bound($urandom % 15)) - ($urandom % 2);
				if ($urandom % 2) begin
					edge_at = ($urandom % 2) ? cur_top + cur_height : cur_top - 1;
					row = (edge_at < 0) ? 0 : (edge_at > 1023) ? 1023 : edge_at;
				end
			end
			send_pixel(b, g, r, 10'(col), 10'(row), i == len - 1, 1'b0);
		end
	endtask

	// Settings for the later random phases, mostly small bands and low fills
	// so that short frames can press keys, with the full ranges mixed in.
	task automatic random_settings();
		int top, height, thresh, fill;
		top    = ($urandom % 3 == 0) ? $urandom % 1024 : $urandom_range(0, 400);
		height = ($urandom % 10 < 7) ? $urandom_range(1, 4) : $urandom % 64;
		thresh = ($urandom % 10 < 7) ? $urandom_range(0, 150) : $urandom % 256;
		fill   = ($urandom % 10 < 7) ? $urandom_range(0, 3) : $urandom % 16;
		program_band(top, height, thresh, fill);
	endtask

	initial begin : stimulus
		int phase;
		int random_start;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A single bright pixel under the reset settings: nothing can press.
		send_pixel(8'd255, 8'd255, 8'd255, 10'd66, 10'd333, 1'b1, 1'b0);

		// Directed frames. With a fill of zero any lit pixel presses its zone,
		// so every zone and band edge shows up directly in the masks. Equal
		// color components give a gray level equal to that component.
		program_band(500, 2, 100, 0);
		send_pixel(8'd0, 8'd0, 8'd0, 10'd66, 10'd500, 1'b1, 1'b0);
		send_pixel(8'd101, 8'd101, 8'd101, 10'd66, 10'd500, 1'b0, 1'b0);
		send_pixel(8'd100, 8'd100, 8'd100, 10'd107, 10'd500, 1'b0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 10'd65, 10'd500, 1'b0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 10'd567, 10'd501, 1'b0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 10'd568, 10'd501, 1'b0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 10'd200, 10'd499, 1'b0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 10'd200, 10'd502, 1'b1, 1'b0);
		// Same key held into the next frame: pressed but no onset.
		send_pixel(8'd255, 8'd255, 8'd255, 10'd106, 10'd500, 1'b1, 1'b0);
		// Each color channel alone at full scale, one zone each.
		send_pixel(8'd255, 8'd0, 8'd0, 10'd145, 10'd500, 1'b0, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd0, 10'd182, 10'd500, 1'b0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd255, 10'd215, 10'd501, 1'b0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 10'd1023, 10'd1023, 1'b1, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 10'd0, 10'd0, 1'b1, 1'b0);

		// Random phases. The first few pin the register extremes: a band at
		// the top with zero fill, a band past the last row with the largest
		// threshold and an unreachable fill, a zero-height band and a fill of
		// exactly ten tenths. Each phase starts from an idle block.
		random_start = pixels_sent;
		phase = 0;
		while (pixels_sent - random_start < RANDOM_PIXELS) begin
			case (phase)
				0: program_band(0, 63, 0, 0);
				1: program_band(1023, 63, 255, 15);
				2: program_band(1000, 63, 50, 1);
				3: program_band(200, 0, 0, 0);
				4: program_band(100, 2, 20, 10);
				default: random_settings();
			endcase
			if (phase == 20) begin
				// Tiny frames against a receiver that stops for a long while.
				hold_asked++;
				repeat (30) send_frame($urandom_range(1, 2));
			end else begin
				repeat ($urandom_range(1, 4))
					send_frame(($urandom % 10 < 3) ? $urandom_range(1, 8) : $urandom_range(8, 40));
			end
			phase++;
		end

		settle();
		repeat (20) @(posedge clk);
		$display("Sent %0d pixels under %0d register settings; checked %0d frame results.",
			pixels_sent, settings_used, frames_checked);
		$display("Covered zone and band edges, register extremes and a long output stall.");
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
